### hw/rtl/fipd_pkg.sv
// Package of the fall impact peak detector: widths, reset values, register
// indexes and the state types shared by the control and the serial units.
// No dependencies.
package fipd_pkg;

  // Field and datapath widths
  localparam int unsigned AXIS_W   = 16;
  localparam int unsigned ENERGY_W = 26;
  localparam int unsigned ROOT_W   = 16;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 26;

  // Scaling by 98/1000 is done as 49/500 on the magnitude
  localparam int unsigned SCALE_MUL = 49;
  localparam int unsigned DIVISOR   = 500;
  localparam int unsigned DIVD_W    = 21;  // 32768 * 49 fits 21 bits
  localparam int unsigned REM_W     = 9;   // remainder below 500
  localparam int unsigned QUO_W     = 12;  // scaled axis at most 3211
  localparam int unsigned SQ_W      = 25;  // sum of three squares
  localparam int unsigned RAD_W     = 32;  // 100 * peak energy

  // Reset values of registers and timers
  localparam logic [ENERGY_W-1:0] THRESH_RST  = 26'd50;
  localparam logic [CNT_W-1:0]    BLINK_RST   = 16'd50;
  localparam logic [CNT_W-1:0]    TIMEOUT_RST = 16'd10000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

  // Detector phase, coded as it appears on the mode output
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_FALLING = 2'd1,
    PH_SHOWING = 2'd2
  } phase_e;

  // Item sequencer in the top level
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ENERGY,
    CS_ROOT,
    CS_PUSH
  } ctl_state_e;

  // Serial scale-and-square unit
  typedef enum logic [1:0] {
    EN_IDLE,
    EN_DIV,
    EN_SQ
  } en_state_e;

  // Serial square root unit
  typedef enum logic {
    RT_IDLE,
    RT_RUN
  } rt_state_e;

endpackage

### hw/rtl/fall_impact_peak_detector_top.sv
// Fall impact peak detector top: phase control, timers, LED and result register.
// A tick, or a poll outside falling, goes from acceptance straight to the result push;
// a falling poll first runs the energy unit on 3 axes, and an impact also the square root.
// One item in work at a time: no new item is accepted until the last is pushed; a result
// waiting unread holds the item in its push state and so holds off the next item.
// Asynchronous active-low reset: phase idle, timers and registers at reset values.
module fall_impact_peak_detector_top
  import fipd_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration writes
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  // input items
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      action_i,
  input  logic signed [AXIS_W-1:0]  acc_x_i,
  input  logic signed [AXIS_W-1:0]  acc_y_i,
  input  logic signed [AXIS_W-1:0]  acc_z_i,
  input  logic                      freefall_seen_i,
  input  logic                      button_pressed_i,
  // result items
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                mode_o,
  output logic                      red_led_o,
  output logic                      fast_clock_o,
  output logic                      impact_o,
  output logic [ROOT_W-1:0]         peak_tenths_o,
  output logic                      display_on_o
);

  // Configuration registers
  logic [ENERGY_W-1:0] thresh_q;
  logic [CNT_W-1:0]    blink_per_q;
  logic [CNT_W-1:0]    timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= THRESH_RST;
      blink_per_q <= BLINK_RST;
      timeout_q   <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: thresh_q    <= cfg_data_i[ENERGY_W-1:0];
        CFG_BLINK:     blink_per_q <= cfg_data_i[CNT_W-1:0];
        CFG_TIMEOUT:   timeout_q   <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Detector state
  ctl_state_e          cs_q, cs_d;
  phase_e              phase_q, phase_d;
  logic [ENERGY_W-1:0] prev_q, prev_d;
  logic [ENERGY_W-1:0] peak_q, peak_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [CNT_W-1:0]    blink_q, blink_d;
  logic [CNT_W-1:0]    show_q, show_d;
  logic                led_q, led_d;
  logic                hit_d;

  // Latched item flags
  logic act_q, ff_q, btn_q;

  // Result register
  logic                out_valid_q, out_valid_d;
  logic [1:0]          mode_q;
  logic                led_out_q, fast_q, impact_q, disp_q;
  logic [ROOT_W-1:0]   tenths_q;

  // Serial units
  logic                en_start, en_done;
  logic [ENERGY_W-1:0] en_energy;
  logic                rt_start, rt_done;
  logic [ROOT_W-1:0]   rt_root;
  logic [RAD_W-1:0]    radicand;

  logic in_fire, push_ok, commit;

  fipd_energy u_energy (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (en_start),
    .acc_x_i  (acc_x_i),
    .acc_y_i  (acc_y_i),
    .acc_z_i  (acc_z_i),
    .done_o   (en_done),
    .energy_o (en_energy)
  );

  fipd_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rt_start),
    .radicand_i (radicand),
    .done_o     (rt_done),
    .root_o     (rt_root)
  );

  // Impact test and running peak from the finished energy
  logic [ENERGY_W-1:0] diff_w;
  logic [ENERGY_W-1:0] peak_new;
  logic [RAD_W-1:0]    peak_ext;
  logic                hit_w;

  assign diff_w   = (en_energy >= prev_q) ? (en_energy - prev_q) : (prev_q - en_energy);
  assign hit_w    = (diff_w >= thresh_q) && (prev_q != '0);
  assign peak_new = (en_energy > peak_q) ? en_energy : peak_q;
  assign peak_ext = {{(RAD_W-ENERGY_W){1'b0}}, peak_new};
  assign radicand = (peak_ext << 6) + (peak_ext << 5) + (peak_ext << 2);

  assign in_fire = in_valid_i && in_ready_o;
  assign push_ok = !out_valid_q || out_ready_i;

  // Sequencer next state
  always_comb begin
    cs_d = cs_q;
    unique case (cs_q)
      CS_IDLE: begin
        if (in_fire) begin
          cs_d = (action_i && (phase_q == PH_FALLING)) ? CS_ENERGY : CS_PUSH;
        end
      end
      CS_ENERGY: if (en_done) cs_d = hit_w ? CS_ROOT : CS_PUSH;
      CS_ROOT:   if (rt_done) cs_d = CS_PUSH;
      CS_PUSH:   if (push_ok) cs_d = CS_IDLE;
      default:   cs_d = CS_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    en_start   = 1'b0;
    rt_start   = 1'b0;
    commit     = 1'b0;
    unique case (cs_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        en_start   = in_valid_i && action_i && (phase_q == PH_FALLING);
      end
      CS_ENERGY: rt_start = en_done && hit_w;
      CS_ROOT:   ;
      CS_PUSH:   commit = push_ok;
      default:   ;
    endcase
  end

  // State update at the end of an item
  always_comb begin
    phase_d = phase_q;
    prev_d  = prev_q;
    peak_d  = peak_q;
    root_d  = root_q;
    blink_d = blink_q;
    show_d  = show_q;
    led_d   = led_q;
    hit_d   = 1'b0;
    if (!act_q) begin
      // millisecond tick
      if (blink_q != '0) blink_d = blink_q - CNT_W'(1);
      if (show_q != '0)  show_d  = show_q - CNT_W'(1);
    end else begin
      case (phase_q)
        PH_FALLING: begin
          if (blink_q == '0) begin
            blink_d = blink_per_q;
            led_d   = !led_q;
          end
          peak_d = peak_new;
          if (hit_w) begin
            show_d  = timeout_q;
            root_d  = rt_root;
            led_d   = 1'b0;
            phase_d = PH_SHOWING;
            hit_d   = 1'b1;
          end
          prev_d = en_energy;
        end
        PH_SHOWING: begin
          if ((show_q == '0) || btn_q) phase_d = PH_IDLE;
        end
        default: begin
          if (ff_q) begin
            prev_d  = '0;
            peak_d  = '0;
            blink_d = blink_per_q;
            phase_d = PH_FALLING;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q    <= CS_IDLE;
      phase_q <= PH_IDLE;
      prev_q  <= '0;
      peak_q  <= '0;
      root_q  <= '0;
      blink_q <= BLINK_RST;
      show_q  <= TIMEOUT_RST;
      led_q   <= 1'b0;
    end else begin
      cs_q <= cs_d;
      if (commit) begin
        phase_q <= phase_d;
        prev_q  <= prev_d;
        peak_q  <= peak_d;
        root_q  <= root_d;
        blink_q <= blink_d;
        show_q  <= show_d;
        led_q   <= led_d;
      end
    end
  end

  // Item flags, held through the work of the item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q <= action_i;
      ff_q  <= freefall_seen_i;
      btn_q <= button_pressed_i;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (commit)      out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      mode_q    <= phase_d;
      led_out_q <= led_d;
      fast_q    <= (phase_d != PH_IDLE);
      impact_q  <= hit_d;
      tenths_q  <= root_d;
      disp_q    <= (phase_d == PH_SHOWING);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign mode_o        = mode_q;
  assign red_led_o     = led_out_q;
  assign fast_clock_o  = fast_q;
  assign impact_o      = impact_q;
  assign peak_tenths_o = tenths_q;
  assign display_on_o  = disp_q;

endmodule

### hw/rtl/fipd_energy.sv
// Bit-serial energy unit: scales each axis by 49/500 through a restoring
// divider, one quotient bit a cycle, then squares it by shift and add.
// Depends on fipd_pkg.
module fipd_energy
  import fipd_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [AXIS_W-1:0]   acc_x_i,
  input  logic signed [AXIS_W-1:0]   acc_y_i,
  input  logic signed [AXIS_W-1:0]   acc_z_i,
  output logic                       done_o,
  output logic [ENERGY_W-1:0]        energy_o
);

  localparam logic [4:0] DIV_LAST = 5'(DIVD_W - 1);
  localparam logic [4:0] SQ_LAST  = 5'(QUO_W - 1);
  localparam logic [REM_W:0] DIV_K = (REM_W + 1)'(DIVISOR);

  // |s| * 49 as the dividend of the divide by 500
  function automatic logic [DIVD_W-1:0] dividend(logic signed [AXIS_W-1:0] s);
    logic [AXIS_W:0]   ext;
    logic [AXIS_W:0]   mag;
    logic [DIVD_W-1:0] m;
    ext = {s[AXIS_W-1], s};
    mag = s[AXIS_W-1] ? (~ext + {{AXIS_W{1'b0}}, 1'b1}) : ext;
    m   = {{(DIVD_W-AXIS_W-1){1'b0}}, mag};
    return (m << 5) + (m << 4) + m;
  endfunction

  en_state_e                 state_q, state_d;
  logic [4:0]                cnt_q, cnt_d;
  logic [1:0]                axis_q, axis_d;
  logic signed [AXIS_W-1:0]  ay_q, ay_d, az_q, az_d;
  logic [DIVD_W-1:0]         div_q, div_d;
  logic [REM_W-1:0]          rem_q, rem_d;
  logic [QUO_W-1:0]          mul_q, mul_d;
  logic [2*QUO_W-1:0]        mcand_q, mcand_d;
  logic [SQ_W-1:0]           acc_q, acc_d;
  logic                      done_q, done_d;

  // Divider and multiplier steps
  logic [REM_W:0]            trial;
  logic                      ge;
  logic [REM_W:0]            rem_sub;
  logic [DIVD_W-1:0]         div_step;
  logic [SQ_W-1:0]           acc_step;

  assign trial    = {rem_q, div_q[DIVD_W-1]};
  assign ge       = (trial >= DIV_K);
  assign rem_sub  = ge ? (trial - DIV_K) : trial;
  assign div_step = {div_q[DIVD_W-2:0], ge};
  assign acc_step = acc_q + (mul_q[0] ? {{(SQ_W-2*QUO_W){1'b0}}, mcand_q} : '0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      EN_IDLE: if (start_i) state_d = EN_DIV;
      EN_DIV:  if (cnt_q == DIV_LAST) state_d = EN_SQ;
      EN_SQ: begin
        if (cnt_q == SQ_LAST) begin
          state_d = (axis_q == 2'd2) ? EN_IDLE : EN_DIV;
        end
      end
      default: state_d = EN_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    cnt_d   = cnt_q;
    axis_d  = axis_q;
    ay_d    = ay_q;
    az_d    = az_q;
    div_d   = div_q;
    rem_d   = rem_q;
    mul_d   = mul_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    done_d  = 1'b0;
    unique case (state_q)
      EN_IDLE: begin
        if (start_i) begin
          div_d  = dividend(acc_x_i);
          ay_d   = acc_y_i;
          az_d   = acc_z_i;
          rem_d  = '0;
          acc_d  = '0;
          cnt_d  = '0;
          axis_d = '0;
        end
      end
      EN_DIV: begin
        div_d = div_step;
        rem_d = rem_sub[REM_W-1:0];
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) begin
          mul_d   = div_step[QUO_W-1:0];
          mcand_d = {{QUO_W{1'b0}}, div_step[QUO_W-1:0]};
          cnt_d   = '0;
        end
      end
      EN_SQ: begin
        acc_d   = acc_step;
        mul_d   = mul_q >> 1;
        mcand_d = mcand_q << 1;
        cnt_d   = cnt_q + 5'd1;
        if (cnt_q == SQ_LAST) begin
          cnt_d = '0;
          if (axis_q == 2'd2) begin
            done_d = 1'b1;
          end else begin
            // bring the next axis in
            div_d  = dividend(ay_q);
            ay_d   = az_q;
            rem_d  = '0;
            axis_d = axis_q + 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EN_IDLE;
      cnt_q   <= '0;
      axis_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ay_q    <= ay_d;
    az_q    <= az_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    mul_q   <= mul_d;
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
  end

  assign done_o   = done_q;
  assign energy_o = {{(ENERGY_W-SQ_W){1'b0}}, acc_q};

endmodule

### hw/rtl/fipd_isqrt.sv
// Serial integer square root, two radicand bits a cycle.
// Depends on fipd_pkg.
module fipd_isqrt
  import fipd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [RAD_W-1:0]   radicand_i,
  output logic               done_o,
  output logic [ROOT_W-1:0]  root_o
);

  localparam int unsigned RW = ROOT_W + 2;  // partial remainder width
  localparam logic [3:0]  LAST = 4'(ROOT_W - 1);

  rt_state_e            state_q, state_d;
  logic [3:0]           cnt_q, cnt_d;
  logic [RAD_W-1:0]     v_q, v_d;
  logic [RW-1:0]        rem_q, rem_d;
  logic [ROOT_W-1:0]    root_q, root_d;
  logic                 done_q, done_d;

  logic [RW+1:0]        part;
  logic [RW+1:0]        trial;
  logic                 ge;
  logic [RW+1:0]        diff;

  assign part  = {rem_q, v_q[RAD_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = (part >= trial);
  assign diff  = ge ? (part - trial) : part;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      RT_IDLE: if (start_i) state_d = RT_RUN;
      RT_RUN:  if (cnt_q == LAST) state_d = RT_IDLE;
      default: state_d = RT_IDLE;
    endcase
  end

  // Digit recurrence
  always_comb begin
    cnt_d  = cnt_q;
    v_d    = v_q;
    rem_d  = rem_q;
    root_d = root_q;
    done_d = 1'b0;
    unique case (state_q)
      RT_IDLE: begin
        if (start_i) begin
          v_d    = radicand_i;
          rem_d  = '0;
          root_d = '0;
          cnt_d  = '0;
        end
      end
      RT_RUN: begin
        v_d    = v_q << 2;
        rem_d  = diff[RW-1:0];
        root_d = {root_q[ROOT_W-2:0], ge};
        cnt_d  = cnt_q + 4'd1;
        done_d = (cnt_q == LAST);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RT_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
